// ===== sv/a2dt_pkg.sv =====
// shared types, constants, codes and helpers for the affine transform composer
package a2dt_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int OP_BITS   = WORD_BITS + 1;
  localparam int PROD_BITS = 2 * OP_BITS;
  localparam int RND_BITS  = PROD_BITS - FRAC_BITS;
  localparam int ACC_BITS  = RND_BITS + 2;
  localparam int RAD_BITS  = 2 * WORD_BITS;
  localparam int QUO_BITS  = 20;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [OP_BITS-1:0]   op_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [RND_BITS-1:0]  rnd_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;
  typedef logic [WORD_BITS-1:0]        mag_t;
  typedef logic [QUO_BITS-1:0]         quo_t;

  localparam op_t   Q_ONE     = op_t'(1) <<< FRAC_BITS;
  localparam op_t   Q_NEG_ONE = -Q_ONE;
  localparam word_t W_ONE     = word_t'(1) <<< FRAC_BITS;
  localparam word_t W_MAX     = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t W_MIN     = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam prod_t P_HALF    = prod_t'(1) <<< (FRAC_BITS - 1);

  localparam logic [3:0] CMD_IDENT    = 4'd0;
  localparam logic [3:0] CMD_SCALE    = 4'd1;
  localparam logic [3:0] CMD_TRANS    = 4'd2;
  localparam logic [3:0] CMD_ROT_VEC  = 4'd3;
  localparam logic [3:0] CMD_ROT_CTR  = 4'd4;
  localparam logic [3:0] CMD_ROT_FT   = 4'd5;
  localparam logic [3:0] CMD_REF_X    = 4'd6;
  localparam logic [3:0] CMD_REF_Y    = 4'd7;
  localparam logic [3:0] CMD_REF_LINE = 4'd8;
  localparam logic [3:0] CMD_MAP      = 4'd9;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  typedef enum logic [3:0] {
    ACT_DONE, ACT_IDENT, ACT_T_SCALE, ACT_T_TRANS_V, ACT_T_TRANS_A, ACT_T_TRANS_N,
    ACT_T_ROT, ACT_T_ROTN, ACT_T_REFX, ACT_T_REFY, ACT_NORM_V, ACT_NORM_A,
    ACT_NORM_D, ACT_DOTCRS, ACT_MAP
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACT, ST_NSHIFT, ST_NSQ, ST_NROOT, ST_MUL, ST_DONE
  } state_t;

  typedef enum logic [1:0] {JOB_COMP, JOB_MAP, JOB_DOT} job_t;

  typedef enum logic [2:0] {
    RD_IDLE, RD_SQRT, RD_LDX, RD_DIVX, RD_LDY, RD_DIVY, RD_DONE
  } rd_state_t;

  // micro-program: the elementary steps of each command
  function automatic act_t next_act(logic [3:0] cmd, logic [2:0] step);
    act_t a;
    a = ACT_DONE;
    unique case (cmd)
      CMD_IDENT:   if (step == 3'd0) a = ACT_IDENT;
      CMD_SCALE:   if (step == 3'd0) a = ACT_T_SCALE;
      CMD_TRANS:   if (step == 3'd0) a = ACT_T_TRANS_V;
      CMD_REF_X:   if (step == 3'd0) a = ACT_T_REFX;
      CMD_REF_Y:   if (step == 3'd0) a = ACT_T_REFY;
      CMD_MAP:     if (step == 3'd0) a = ACT_MAP;
      CMD_ROT_VEC: begin
        unique case (step)
          3'd0:    a = ACT_NORM_V;
          3'd1:    a = ACT_T_ROT;
          default: a = ACT_DONE;
        endcase
      end
      CMD_ROT_CTR: begin
        unique case (step)
          3'd0:    a = ACT_NORM_V;
          3'd1:    a = ACT_T_TRANS_N;
          3'd2:    a = ACT_T_ROT;
          3'd3:    a = ACT_T_TRANS_A;
          default: a = ACT_DONE;
        endcase
      end
      CMD_ROT_FT: begin
        unique case (step)
          3'd0:    a = ACT_NORM_V;
          3'd1:    a = ACT_NORM_A;
          3'd2:    a = ACT_DOTCRS;
          3'd3:    a = ACT_NORM_D;
          3'd4:    a = ACT_T_ROT;
          default: a = ACT_DONE;
        endcase
      end
      CMD_REF_LINE: begin
        unique case (step)
          3'd0:    a = ACT_NORM_V;
          3'd1:    a = ACT_T_TRANS_N;
          3'd2:    a = ACT_T_ROTN;
          3'd3:    a = ACT_T_REFX;
          3'd4:    a = ACT_T_ROT;
          3'd5:    a = ACT_T_TRANS_A;
          default: a = ACT_DONE;
        endcase
      end
      default: a = ACT_DONE;
    endcase
    return a;
  endfunction

  function automatic logic acc_ovf(acc_t v);
    return !((&v[ACC_BITS-1:WORD_BITS-1]) || !(|v[ACC_BITS-1:WORD_BITS-1]));
  endfunction

  function automatic word_t acc_sat(acc_t v);
    word_t r;
    if (acc_ovf(v)) begin
      r = v[ACC_BITS-1] ? W_MIN : W_MAX;
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic op_t w2op(word_t w);
    return {w[WORD_BITS-1], w};
  endfunction

endpackage

// ===== sv/a2dt_rootdiv.sv =====
// iterative integer square root followed by two restoring divides
module a2dt_rootdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [a2dt_pkg::RAD_BITS-1:0] radicand,
  input  a2dt_pkg::mag_t                num_x,
  input  a2dt_pkg::mag_t                num_y,
  output logic                          done,
  output a2dt_pkg::quo_t                quo_x,
  output a2dt_pkg::quo_t                quo_y
);
  import a2dt_pkg::*;

  localparam logic [RAD_BITS-1:0] BIT_TOP = {2'b01, {(RAD_BITS-2){1'b0}}};

  rd_state_t             state_r, state_nxt;
  logic [RAD_BITS-1:0]   rad_r, rad_nxt, root_r, root_nxt, bit_r, bit_nxt, trial;
  logic [4:0]            cnt_r, cnt_nxt;
  mag_t                  nx_r, nx_nxt, ny_r, ny_nxt, rem_r, rem_nxt, rt;
  quo_t                  sh_r, sh_nxt, quo_r, quo_nxt, qx_r, qx_nxt;
  logic [NUM_BITS-1:0]   numv;
  logic [WORD_BITS:0]    rem2, diff;
  mag_t                  nsel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    cnt_r  <= cnt_nxt;
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    quo_r  <= quo_nxt;
    qx_r   <= qx_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    rad_nxt   = rad_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    cnt_nxt   = cnt_r;
    nx_nxt    = nx_r;
    ny_nxt    = ny_r;
    rem_nxt   = rem_r;
    sh_nxt    = sh_r;
    quo_nxt   = quo_r;
    qx_nxt    = qx_r;
    trial     = root_r + bit_r;
    rt        = root_r[WORD_BITS-1:0];
    nsel      = (state_r == RD_LDY) ? ny_r : nx_r;
    numv      = {1'b0, nsel, {FRAC_BITS{1'b0}}} + NUM_BITS'(rt >> 1);
    rem2      = {rem_r, sh_r[QUO_BITS-1]};
    diff      = rem2 - {1'b0, rt};
    unique case (state_r)
      RD_IDLE: begin
        if (start) begin
          rad_nxt   = radicand;
          root_nxt  = '0;
          bit_nxt   = BIT_TOP;
          cnt_nxt   = '0;
          nx_nxt    = num_x;
          ny_nxt    = num_y;
          state_nxt = RD_SQRT;
        end
      end
      RD_SQRT: begin
        if (rad_r >= trial) begin
          rad_nxt  = rad_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = RD_LDX;
      end
      RD_LDX, RD_LDY: begin
        rem_nxt = WORD_BITS'(numv[NUM_BITS-1:QUO_BITS]);
        sh_nxt  = numv[QUO_BITS-1:0];
        cnt_nxt = '0;
        if (state_r == RD_LDY) qx_nxt = quo_r;
        state_nxt = (state_r == RD_LDX) ? RD_DIVX : RD_DIVY;
      end
      RD_DIVX, RD_DIVY: begin
        if (!diff[WORD_BITS]) begin
          rem_nxt = diff[WORD_BITS-1:0];
          quo_nxt = {quo_r[QUO_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = rem2[WORD_BITS-1:0];
          quo_nxt = {quo_r[QUO_BITS-2:0], 1'b0};
        end
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(QUO_BITS - 1)) begin
          state_nxt = (state_r == RD_DIVX) ? RD_LDY : RD_DONE;
        end
      end
      RD_DONE: state_nxt = RD_IDLE;
      default: state_nxt = RD_IDLE;
    endcase
  end

  assign done  = (state_r == RD_DONE);
  assign quo_x = qx_r;
  assign quo_y = quo_r;

endmodule

// ===== sv/affine_2d_transform_composer_unit.sv =====
// top level: 2d affine matrix composer with shared multiplier and root/divide unit
//
//  channel | ports                                   | dir | handshake
//  request | in_cmd in_val_x in_val_y in_aux_x in_aux_y | in  | in_valid / in_ready
//  result  | out_x out_y out_status                   | out | out_valid / out_ready
//
// one request at a time; in_ready is high only while the sequencer is idle
// each elementary matrix step runs 12 products through the one pipelined multiplier
// each vector normalization adds up to 30 alignment shifts,
// a 32-step square root and two 20-step divides in the root/divide unit
// the result register lets the next request start while a result waits;
// synchronous reset loads the identity matrix
module affine_2d_transform_composer_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [3:0]      in_cmd,
  input  a2dt_pkg::word_t in_val_x,
  input  a2dt_pkg::word_t in_val_y,
  input  a2dt_pkg::word_t in_aux_x,
  input  a2dt_pkg::word_t in_aux_y,
  output logic            out_valid,
  input  logic            out_ready,
  output a2dt_pkg::word_t out_x,
  output a2dt_pkg::word_t out_y,
  output logic [1:0]      out_status
);
  import a2dt_pkg::*;

  state_t      state_r, state_nxt;
  logic [3:0]  cmd_r, cmd_nxt;
  word_t       vx_r, vx_nxt, vy_r, vy_nxt, ax_r, ax_nxt, ay_r, ay_nxt;
  logic [2:0]  step_r, step_nxt;
  word_t       coef_r [6];
  word_t       coef_nxt [6];
  op_t         t_r [6];
  op_t         t_nxt [6];
  word_t       res_r [6];
  word_t       res_nxt [6];
  op_t         c_r, c_nxt, s_r, s_nxt, c2_r, c2_nxt, s2_r, s2_nxt;
  logic        zero_r, zero_nxt, sat_r, sat_nxt;
  job_t        job_r, job_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  mag_t        nx_r, nx_nxt, ny_r, ny_nxt;
  logic        nsx_r, nsx_nxt, nsy_r, nsy_nxt, ntgt_r, ntgt_nxt;
  logic [RAD_BITS-1:0] sumsq_r, sumsq_nxt;

  logic        v1_r, sq1_r, k1_r, sub1_r, v2_r, k2_r, sub2_r;
  logic [2:0]  o1_r, o2_r;
  prod_t       prod_r, prod_sum;
  rnd_t        rnd_r;
  acc_t        acc_r, acc_nxt, acc_sum, init_v, rnd_ext;

  logic        iss, iss_sq, iss_k, iss_sub;
  logic [2:0]  iss_o, row3, col, ta, cb;
  op_t         mul_a, mul_b;

  logic        out_valid_r, out_valid_nxt;
  word_t       ox_r, ox_nxt, oy_r, oy_nxt;
  logic [1:0]  ost_r, ost_nxt;

  act_t        act;
  word_t       src_x, src_y, negx, negy;
  mag_t        magx, magy;
  logic        rd_start, rd_done;
  quo_t        qx, qy;
  op_t         qxe, qye, cq, sq;
  logic [3:0]  n_ops;

  a2dt_rootdiv u_rootdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rd_start),
    .radicand (sumsq_r),
    .num_x    (nx_r),
    .num_y    (ny_r),
    .done     (rd_done),
    .quo_x    (qx),
    .quo_y    (qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      coef_r[0]   <= W_ONE;
      coef_r[1]   <= '0;
      coef_r[2]   <= '0;
      coef_r[3]   <= '0;
      coef_r[4]   <= W_ONE;
      coef_r[5]   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      v1_r        <= iss;
      v2_r        <= v1_r && !sq1_r;
      for (int i = 0; i < 6; i++) coef_r[i] <= coef_nxt[i];
    end
    for (int i = 0; i < 6; i++) begin
      t_r[i]   <= t_nxt[i];
      res_r[i] <= res_nxt[i];
    end
    cmd_r   <= cmd_nxt;
    vx_r    <= vx_nxt;
    vy_r    <= vy_nxt;
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    step_r  <= step_nxt;
    c_r     <= c_nxt;
    s_r     <= s_nxt;
    c2_r    <= c2_nxt;
    s2_r    <= s2_nxt;
    zero_r  <= zero_nxt;
    sat_r   <= sat_nxt;
    job_r   <= job_nxt;
    cnt_r   <= cnt_nxt;
    nx_r    <= nx_nxt;
    ny_r    <= ny_nxt;
    nsx_r   <= nsx_nxt;
    nsy_r   <= nsy_nxt;
    ntgt_r  <= ntgt_nxt;
    sumsq_r <= sumsq_nxt;
    prod_r  <= mul_a * mul_b;
    sq1_r   <= iss_sq;
    k1_r    <= iss_k;
    o1_r    <= iss_o;
    sub1_r  <= iss_sub;
    k2_r    <= k1_r;
    o2_r    <= o1_r;
    sub2_r  <= sub1_r;
    rnd_r   <= prod_sum[PROD_BITS-1:FRAC_BITS];
    acc_r   <= acc_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    ost_r   <= ost_nxt;
  end

  // multiplier operand select
  always_comb begin
    iss     = 1'b0;
    iss_sq  = 1'b0;
    iss_k   = cnt_r[0];
    iss_o   = cnt_r[3:1];
    iss_sub = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    row3    = (iss_o >= 3'd3) ? 3'd3 : 3'd0;
    col     = iss_o - row3;
    ta      = row3 + {2'b00, iss_k};
    cb      = (iss_k ? 3'd3 : 3'd0) + col;
    n_ops   = (job_r == JOB_COMP) ? 4'd12 : 4'd4;
    if (state_r == ST_MUL && cnt_r < n_ops) begin
      iss = 1'b1;
      unique case (job_r)
        JOB_COMP: begin
          mul_a = t_r[ta];
          mul_b = w2op(coef_r[cb]);
        end
        JOB_MAP: begin
          mul_a = w2op(coef_r[(iss_o[0] ? 3'd3 : 3'd0) + {2'b00, iss_k}]);
          mul_b = w2op(iss_k ? vy_r : vx_r);
        end
        default: begin
          iss_sub = (cnt_r == 4'd3);
          mul_a   = iss_k ? s_r : c_r;
          mul_b   = (iss_k ^ iss_o[0]) ? s2_r : c2_r;
        end
      endcase
    end else if (state_r == ST_NSQ && cnt_r < 4'd2) begin
      iss    = 1'b1;
      iss_sq = 1'b1;
      mul_a  = {1'b0, cnt_r[0] ? ny_r : nx_r};
      mul_b  = mul_a;
    end
  end

  assign prod_sum = prod_r + P_HALF;
  assign rnd_ext  = {{(ACC_BITS-RND_BITS){rnd_r[RND_BITS-1]}}, rnd_r};

  always_comb begin
    init_v = '0;
    unique case (job_r)
      JOB_COMP: if (o2_r == 3'd2 || o2_r == 3'd5) init_v = ACC_BITS'(t_r[o2_r]);
      JOB_MAP:  init_v = ACC_BITS'(o2_r[0] ? coef_r[5] : coef_r[2]);
      default:  init_v = '0;
    endcase
    acc_sum = sub2_r ? (acc_r - rnd_ext) : (acc_r + rnd_ext);
  end

  assign act  = next_act(cmd_r, step_r);
  assign negx = (ax_r == W_MIN) ? W_MAX : -ax_r;
  assign negy = (ay_r == W_MIN) ? W_MAX : -ay_r;
  assign qxe  = {{(OP_BITS-QUO_BITS){1'b0}}, qx};
  assign qye  = {{(OP_BITS-QUO_BITS){1'b0}}, qy};
  assign cq   = nsx_r ? -qxe : qxe;
  assign sq   = nsy_r ? -qye : qye;
  assign magx = src_x[WORD_BITS-1] ? mag_t'(-src_x) : mag_t'(src_x);
  assign magy = src_y[WORD_BITS-1] ? mag_t'(-src_y) : mag_t'(src_y);
  assign rd_start = (state_r == ST_NSQ) && (cnt_r == 4'd2) && !v1_r;

  always_comb begin
    src_x = vx_r;
    src_y = vy_r;
    unique case (act)
      ACT_NORM_A: begin
        src_x = ax_r;
        src_y = ay_r;
      end
      ACT_NORM_D: begin
        src_x = res_r[0];
        src_y = res_r[1];
      end
      default: begin
        src_x = vx_r;
        src_y = vy_r;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    step_nxt  = step_r;
    for (int i = 0; i < 6; i++) begin
      coef_nxt[i] = coef_r[i];
      t_nxt[i]    = t_r[i];
      res_nxt[i]  = res_r[i];
    end
    c_nxt     = c_r;
    s_nxt     = s_r;
    c2_nxt    = c2_r;
    s2_nxt    = s2_r;
    zero_nxt  = zero_r;
    sat_nxt   = sat_r;
    job_nxt   = job_r;
    cnt_nxt   = iss ? cnt_r + 4'd1 : cnt_r;
    nx_nxt    = nx_r;
    ny_nxt    = ny_r;
    nsx_nxt   = nsx_r;
    nsy_nxt   = nsy_r;
    ntgt_nxt  = ntgt_r;
    sumsq_nxt = sumsq_r;
    acc_nxt   = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    ost_nxt   = ost_r;
    in_ready  = (state_r == ST_IDLE);

    // square accumulation
    if (v1_r && sq1_r) begin
      sumsq_nxt = (k1_r ? sumsq_r : '0) + prod_r[RAD_BITS-1:0];
    end
    // rounded product accumulation
    if (v2_r) begin
      if (!k2_r) begin
        acc_nxt = init_v + rnd_ext;
      end else begin
        res_nxt[o2_r] = acc_sat(acc_sum);
        if (acc_ovf(acc_sum)) sat_nxt = 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          vx_nxt    = in_val_x;
          vy_nxt    = in_val_y;
          ax_nxt    = in_aux_x;
          ay_nxt    = in_aux_y;
          step_nxt  = '0;
          zero_nxt  = 1'b0;
          sat_nxt   = 1'b0;
          state_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        cnt_nxt  = '0;
        job_nxt  = JOB_COMP;
        step_nxt = step_r + 3'd1;
        state_nxt = ST_MUL;
        unique case (act)
          ACT_DONE: begin
            step_nxt  = step_r;
            state_nxt = ST_DONE;
          end
          ACT_IDENT: begin
            coef_nxt[0] = W_ONE;
            coef_nxt[1] = '0;
            coef_nxt[2] = '0;
            coef_nxt[3] = '0;
            coef_nxt[4] = W_ONE;
            coef_nxt[5] = '0;
            state_nxt   = ST_ACT;
          end
          ACT_NORM_V, ACT_NORM_A, ACT_NORM_D: begin
            step_nxt = step_r;
            nx_nxt   = magx;
            ny_nxt   = magy;
            nsx_nxt  = src_x[WORD_BITS-1];
            nsy_nxt  = src_y[WORD_BITS-1];
            ntgt_nxt = (act == ACT_NORM_A);
            if (magx == '0 && magy == '0) begin
              zero_nxt  = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_NSHIFT;
            end
          end
          ACT_DOTCRS: job_nxt = JOB_DOT;
          ACT_MAP:    job_nxt = JOB_MAP;
          default: begin
            t_nxt[0] = Q_ONE;
            t_nxt[1] = '0;
            t_nxt[2] = '0;
            t_nxt[3] = '0;
            t_nxt[4] = Q_ONE;
            t_nxt[5] = '0;
            case (act)
              ACT_T_SCALE: begin
                t_nxt[0] = w2op(vx_r);
                t_nxt[4] = w2op(vy_r);
              end
              ACT_T_TRANS_V: begin
                t_nxt[2] = w2op(vx_r);
                t_nxt[5] = w2op(vy_r);
              end
              ACT_T_TRANS_A: begin
                t_nxt[2] = w2op(ax_r);
                t_nxt[5] = w2op(ay_r);
              end
              ACT_T_TRANS_N: begin
                t_nxt[2] = w2op(negx);
                t_nxt[5] = w2op(negy);
                if (ax_r == W_MIN || ay_r == W_MIN) sat_nxt = 1'b1;
              end
              ACT_T_ROT: begin
                t_nxt[0] = c_r;
                t_nxt[1] = -s_r;
                t_nxt[3] = s_r;
                t_nxt[4] = c_r;
              end
              ACT_T_ROTN: begin
                t_nxt[0] = c_r;
                t_nxt[1] = s_r;
                t_nxt[3] = -s_r;
                t_nxt[4] = c_r;
              end
              ACT_T_REFX: t_nxt[4] = Q_NEG_ONE;
              ACT_T_REFY: t_nxt[0] = Q_NEG_ONE;
              default:    t_nxt[0] = Q_ONE;
            endcase
          end
        endcase
      end
      ST_NSHIFT: begin
        if (nx_r[WORD_BITS-1:WORD_BITS-2] == 2'b00 &&
            ny_r[WORD_BITS-1:WORD_BITS-2] == 2'b00) begin
          nx_nxt = nx_r << 1;
          ny_nxt = ny_r << 1;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_NSQ;
        end
      end
      ST_NSQ: begin
        if (rd_start) state_nxt = ST_NROOT;
      end
      ST_NROOT: begin
        if (rd_done) begin
          if (ntgt_r) begin
            c2_nxt = cq;
            s2_nxt = sq;
          end else begin
            c_nxt = cq;
            s_nxt = sq;
          end
          step_nxt  = step_r + 3'd1;
          state_nxt = ST_ACT;
        end
      end
      ST_MUL: begin
        if (cnt_r == n_ops && !v1_r && !v2_r) begin
          if (job_r == JOB_COMP) begin
            for (int i = 0; i < 6; i++) coef_nxt[i] = res_r[i];
          end
          state_nxt = ST_ACT;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          ox_nxt  = (cmd_r == CMD_MAP) ? res_r[0] : '0;
          oy_nxt  = (cmd_r == CMD_MAP) ? res_r[1] : '0;
          ost_nxt = zero_r ? STAT_ZERO : (sat_r ? STAT_SAT : STAT_OK);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_x      = ox_r;
  assign out_y      = oy_r;
  assign out_status = ost_r;

endmodule

// ===== tb/affine_transform_checker.sv =====
// checker for the affine transform composer: matrix predictor and result scoreboard
module affine_transform_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [3:0]      in_cmd,
  input  a2dt_pkg::word_t in_val_x,
  input  a2dt_pkg::word_t in_val_y,
  input  a2dt_pkg::word_t in_aux_x,
  input  a2dt_pkg::word_t in_aux_y,
  input  logic            out_valid,
  input  logic            out_ready,
  input  a2dt_pkg::word_t out_x,
  input  a2dt_pkg::word_t out_y,
  input  logic [1:0]      out_status,
  output int              mismatches,
  output int              pending,
  output int              results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import a2dt_pkg::*;

  typedef struct packed {
    word_t      x;
    word_t      y;
    logic [1:0] status;
  } point_result_t;

  localparam longint QV   = longint'(1) << FRAC_BITS;
  localparam longint QH   = longint'(1) << (FRAC_BITS - 1);
  localparam longint WTOP = (longint'(1) << (WORD_BITS - 1)) - 1;
  localparam longint WBOT = -WTOP - 1;

  longint        matrix [6];
  bit            clipped;
  point_result_t expected_points [$];

  function automatic longint clip(longint v);
    if (v > WTOP) begin
      clipped = 1'b1;
      return WTOP;
    end
    if (v < WBOT) begin
      clipped = 1'b1;
      return WBOT;
    end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + QH) >>> FRAC_BITS;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit normalize(longint x, longint y, output longint c, output longint s);
    longint unsigned ax, ay, m, r, qx, qy;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    m = ax > ay ? ax : ay;
    c = 0;
    s = 0;
    if (m == 0) return 1'b0;
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      ax <<= 1;
      ay <<= 1;
    end
    r = root64(ax * ax + ay * ay);
    qx = ((ax << FRAC_BITS) + (r >> 1)) / r;
    qy = ((ay << FRAC_BITS) + (r >> 1)) / r;
    c = x < 0 ? -longint'(qx) : longint'(qx);
    s = y < 0 ? -longint'(qy) : longint'(qy);
    return 1'b1;
  endfunction

  function automatic void premultiply(longint a, longint b, longint c,
                                      longint d, longint e, longint f);
    longint t [6];
    longint n [6];
    t = '{a, b, c, d, e, f};
    for (int i = 0; i < 2; i++) begin
      n[3*i]   = clip(qmul(t[3*i], matrix[0]) + qmul(t[3*i+1], matrix[3]));
      n[3*i+1] = clip(qmul(t[3*i], matrix[1]) + qmul(t[3*i+1], matrix[4]));
      n[3*i+2] = clip(qmul(t[3*i], matrix[2]) + qmul(t[3*i+1], matrix[5]) + t[3*i+2]);
    end
    matrix = n;
  endfunction

  function automatic void rotate(longint c, longint s);
    premultiply(c, -s, 0, s, c, 0);
  endfunction

  function automatic point_result_t apply_command(logic [3:0] cmd, word_t wvx, word_t wvy,
                                                  word_t wax, word_t way);
    longint vx, vy, ax, ay, c, s, c2, s2, dot, crs;
    point_result_t res;
    bit degenerate;
    res = '0;
    degenerate = 1'b0;
    clipped = 1'b0;
    vx = clip(longint'(wvx));
    vy = clip(longint'(wvy));
    ax = clip(longint'(wax));
    ay = clip(longint'(way));
    case (cmd)
      CMD_IDENT: matrix = '{QV, 0, 0, 0, QV, 0};
      CMD_SCALE: premultiply(vx, 0, 0, 0, vy, 0);
      CMD_TRANS: premultiply(QV, 0, vx, 0, QV, vy);
      CMD_ROT_VEC: begin
        if (!normalize(vx, vy, c, s)) degenerate = 1'b1;
        else rotate(c, s);
      end
      CMD_ROT_CTR: begin
        if (!normalize(vx, vy, c, s)) begin
          degenerate = 1'b1;
        end else begin
          premultiply(QV, 0, clip(-ax), 0, QV, clip(-ay));
          rotate(c, s);
          premultiply(QV, 0, ax, 0, QV, ay);
        end
      end
      CMD_ROT_FT: begin
        if (!normalize(vx, vy, c, s) || !normalize(ax, ay, c2, s2)) begin
          degenerate = 1'b1;
        end else begin
          dot = qmul(c, c2) + qmul(s, s2);
          crs = qmul(c, s2) - qmul(s, c2);
          if (!normalize(dot, crs, c, s)) degenerate = 1'b1;
          else rotate(c, s);
        end
      end
      CMD_REF_X: premultiply(QV, 0, 0, 0, -QV, 0);
      CMD_REF_Y: premultiply(-QV, 0, 0, 0, QV, 0);
      CMD_REF_LINE: begin
        if (!normalize(vx, vy, c, s)) begin
          degenerate = 1'b1;
        end else begin
          premultiply(QV, 0, clip(-ax), 0, QV, clip(-ay));
          rotate(c, -s);
          premultiply(QV, 0, 0, 0, -QV, 0);
          rotate(c, s);
          premultiply(QV, 0, ax, 0, QV, ay);
        end
      end
      CMD_MAP: begin
        res.x = word_t'(clip(qmul(matrix[0], vx) + qmul(matrix[1], vy) + matrix[2]));
        res.y = word_t'(clip(qmul(matrix[3], vx) + qmul(matrix[4], vy) + matrix[5]));
      end
      default: ;
    endcase
    if (degenerate) res.status = STAT_ZERO;
    else if (clipped) res.status = STAT_SAT;
    else res.status = STAT_OK;
    return res;
  endfunction

  assign pending = expected_points.size();

  always @(posedge clk) begin
    point_result_t want;
    if (!rst_n) begin
      matrix = '{QV, 0, 0, 0, QV, 0};
      expected_points.delete();
      mismatches <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h status=%0d", $time,
                   out_x, out_y, out_status);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_points.pop_front();
          if (want.x !== out_x || want.y !== out_y || want.status !== out_status) begin
            $display("%0t: mismatch expected x=%h y=%h status=%0d actual x=%h y=%h status=%0d",
                     $time, want.x, want.y, want.status, out_x, out_y, out_status);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready)
        expected_points.push_back(apply_command(in_cmd, in_val_x, in_val_y,
                                                in_aux_x, in_aux_y));
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// testbench top: request stimulus, result back-pressure and verdict for the composer
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import a2dt_pkg::*;

  localparam int RANDOM_REQUESTS = 1700;
  localparam int CYCLE_LIMIT     = 4000000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [3:0] in_cmd;
  word_t      in_val_x, in_val_y, in_aux_x, in_aux_y;
  logic       out_valid;
  logic       out_ready;
  word_t      out_x, out_y;
  logic [1:0] out_status;
  int         mismatches, pending, results_seen;
  int         requests_sent;
  int         cycles;
  bit         no_idle;

  affine_2d_transform_composer_unit dut (.*);

  affine_transform_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ready <= no_idle || ($urandom_range(0, 99) >= 26);
  end

  task automatic send_request(logic [3:0] cmd, word_t vx, word_t vy, word_t ax, word_t ay);
    if (!no_idle && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < 26) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_val_x <= vx;
    in_val_y <= vy;
    in_aux_x <= ax;
    in_aux_y <= ay;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    requests_sent++;
    @(negedge clk);
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(0, 9))
      0:       return word_t'($urandom);
      1:       return $urandom_range(0, 1) ? W_MAX : W_MIN;
      2:       return '0;
      3:       return $urandom_range(0, 1) ? W_ONE : -W_ONE;
      default: return word_t'($urandom_range(0, 32'h80000)) - word_t'(32'h40000);
    endcase
  endfunction

  function automatic word_t near_one();
    return W_ONE + word_t'($urandom_range(0, 32'h8000)) - word_t'(32'h4000);
  endfunction

  initial begin
    logic [3:0] cmd;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_cmd    = CMD_IDENT;
    in_val_x  = '0;
    in_val_y  = '0;
    in_aux_x  = '0;
    in_aux_y  = '0;
    out_ready = 1'b0;
    cycles    = 0;
    no_idle   = 1'b0;
    requests_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    send_request(CMD_MAP, W_ONE, -W_ONE, '0, '0);
    send_request(CMD_SCALE, W_MAX, W_MIN, '0, '0);
    send_request(CMD_MAP, W_MAX, W_MIN, '0, '0);
    send_request(CMD_IDENT, '0, '0, '0, '0);
    send_request(CMD_TRANS, W_MAX, W_MIN, '0, '0);
    send_request(CMD_IDENT, '0, '0, '0, '0);
    send_request(CMD_ROT_VEC, '0, '0, '0, '0);
    send_request(CMD_ROT_VEC, W_MIN, W_MIN, '0, '0);
    send_request(CMD_ROT_CTR, 32'sd1, '0, W_MIN, W_MIN);
    send_request(CMD_ROT_CTR, '0, '0, W_ONE, W_ONE);
    send_request(CMD_IDENT, '0, '0, '0, '0);
    send_request(CMD_ROT_FT, W_ONE, '0, '0, W_ONE);
    send_request(CMD_ROT_FT, W_ONE, '0, '0, '0);
    send_request(CMD_ROT_FT, '0, '0, W_ONE, '0);
    send_request(CMD_ROT_FT, W_MAX, W_MAX, W_MIN, W_MIN);
    send_request(CMD_REF_X, '0, '0, '0, '0);
    send_request(CMD_REF_Y, '0, '0, '0, '0);
    send_request(CMD_REF_LINE, W_ONE, W_ONE, W_MIN, W_ONE);
    send_request(CMD_REF_LINE, '0, '0, W_ONE, W_ONE);
    send_request(CMD_MAP, W_ONE, 2 * W_ONE, '0, '0);
    send_request(4'd10, W_MAX, W_MAX, W_MAX, W_MAX);
    send_request(4'd15, W_MIN, W_MIN, W_MIN, W_MIN);
    send_request(CMD_MAP, -W_ONE, W_ONE, '0, '0);

    // hold off until the composer has drained
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    // random transform programs ending in point mappings, plus noise
    while (requests_sent < RANDOM_REQUESTS + 23) begin
      no_idle = (requests_sent > 600 && requests_sent < 900);
      if ($urandom_range(0, 99) < 15) begin
        send_request(4'($urandom), word_t'($urandom), word_t'($urandom),
                     word_t'($urandom), word_t'($urandom));
      end else begin
        if ($urandom_range(0, 2) != 0) send_request(CMD_IDENT, pick_value(), '0, '0, '0);
        repeat ($urandom_range(1, 4)) begin
          cmd = 4'($urandom_range(1, 8));
          if (cmd == CMD_SCALE && $urandom_range(0, 3) != 0)
            send_request(cmd, near_one(), near_one(), pick_value(), pick_value());
          else
            send_request(cmd, pick_value(), pick_value(), pick_value(), pick_value());
        end
        repeat ($urandom_range(1, 3))
          send_request(CMD_MAP, pick_value(), pick_value(), pick_value(), pick_value());
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    $display("sent %0d requests over all commands, checked %0d results", requests_sent,
             results_seen);
    $display("covered zero vectors, saturation, unused commands and back-pressure");
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
